FILE: design/pra_pkg.sv
// ----------------------------------------------------------------------------
// pra_pkg
// Types and constants shared by the page run allocator.
// ----------------------------------------------------------------------------
package pra_pkg;

    localparam int FIELD_BITS = 40;
    localparam int TOTAL_BITS = 41;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_ALLOC = 2'd0;
    localparam kind_t KIND_FREE  = 2'd1;
    localparam kind_t KIND_TAKE  = 2'd2;

    typedef struct packed {
        kind_t                   kind;
        logic [FIELD_BITS-1:0]   page_number;
        logic [FIELD_BITS-1:0]   page_count;
    } req_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0]   result_page;
        logic                    ok;
        logic [FIELD_BITS-1:0]   pages_lost;
        logic [TOTAL_BITS-1:0]   total_free;
    } rsp_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ALLOC_RD,
        S_ALLOC_CHK,
        S_TAKE_RD,
        S_TAKE_CHK,
        S_INS_START,
        S_POS_RD,
        S_POS_CHK,
        S_INS_DEC,
        S_MIN_RD,
        S_MIN_CHK,
        S_MIN_END,
        S_DROP_RD,
        S_DROP_WR,
        S_UP_START,
        S_UP_RD,
        S_UP_WR,
        S_DONE
    } state_t;

endpackage

FILE: design/pra_ram.sv
// ----------------------------------------------------------------------------
// pra_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module pra_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: design/pra_engine.sv
// ----------------------------------------------------------------------------
// pra_engine
// Sequencer for the run table: scans, merges, evicts and shifts entries
// held in the run RAM, one entry access per step.
// ----------------------------------------------------------------------------
module pra_engine #(
    parameter int RUN_SLOTS        = 128,
    parameter int PAGE_NUMBER_BITS = 40
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  pra_pkg::req_t                     req,
    input  logic                              load_ok,
    output logic                              done,
    output pra_pkg::rsp_t                     result,
    output logic                              rd_en,
    output logic [$clog2(RUN_SLOTS)-1:0]      rd_addr,
    input  logic [2*PAGE_NUMBER_BITS-1:0]     rd_data,
    output logic                              wr_en,
    output logic [$clog2(RUN_SLOTS)-1:0]      wr_addr,
    output logic [2*PAGE_NUMBER_BITS-1:0]     wr_data
);

    localparam int W  = PAGE_NUMBER_BITS;
    localparam int AW = $clog2(RUN_SLOTS);
    localparam int UW = $clog2(RUN_SLOTS + 1);
    localparam int DW = (W > pra_pkg::FIELD_BITS) ? W : pra_pkg::FIELD_BITS;
    localparam int TB = pra_pkg::TOTAL_BITS;
    localparam logic [W-1:0] LIMIT = '1;

    pra_pkg::state_t state_reg, state_next, ret_reg, ret_next;
    logic [UW-1:0]   idx_reg, idx_next, used_reg, used_next, pos_reg, pos_next;
    logic [UW-1:0]   small_reg, small_next;
    logic [TB-1:0]   total_reg, total_next;
    pra_pkg::kind_t  kind_reg, kind_next;
    logic [W-1:0]    first_reg, first_next, len_reg, len_next;
    logic [DW-1:0]   cnt_reg, cnt_next;
    logic [W-1:0]    prev_s_reg, prev_s_next, prev_l_reg, prev_l_next;
    logic [W-1:0]    cur_s_reg, cur_s_next, cur_l_reg, cur_l_next;
    logic [W-1:0]    min_l_reg, min_l_next;
    logic [W-1:0]    result_reg, result_next, lost_reg, lost_next;
    logic            ok_reg, ok_next;

    logic [W-1:0]    e_s, e_l, page_in, room, clip_len;
    logic [W-1:0]    alloc_len, tk_keep, tk_after;
    logic [UW-1:0]   idx_inc, idx_dec;
    logic            fit, hit, pos_less, has_prev, has_cur, mprev, mnext, full;
    logic            last, drop_more, min_take;

    assign e_s      = rd_data[2*W-1:W];
    assign e_l      = rd_data[W-1:0];
    assign page_in  = W'(req.page_number);
    assign room     = LIMIT - page_in;
    assign clip_len = (page_in == LIMIT) ? '0 :
                      (DW'(req.page_count) > DW'(room)) ? room : W'(req.page_count);
    assign idx_inc  = idx_reg + UW'(1);
    assign idx_dec  = idx_reg - UW'(1);

    assign fit       = DW'(e_l) >= cnt_reg;
    assign alloc_len = e_l - W'(cnt_reg);
    assign hit       = (first_reg >= e_s) && ((first_reg - e_s) < e_l);
    assign tk_keep   = first_reg - e_s;
    assign tk_after  = e_s + e_l - first_reg - W'(1);
    assign pos_less  = e_s < first_reg;
    assign has_prev  = idx_reg != '0;
    assign has_cur   = idx_reg < used_reg;
    assign mprev     = has_prev &&
                       ((W+1)'(prev_s_reg) + (W+1)'(prev_l_reg) == (W+1)'(first_reg));
    assign mnext     = has_cur &&
                       ((W+1)'(first_reg) + (W+1)'(len_reg) == (W+1)'(cur_s_reg));
    assign full      = used_reg >= UW'(RUN_SLOTS);
    assign last      = idx_inc == used_reg;
    assign drop_more = idx_inc < used_reg;
    assign min_take  = (idx_reg == '0) || (e_l < min_l_reg);

    assign req_stall = state_reg != pra_pkg::S_IDLE;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pra_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    unique case (req.kind)
                        pra_pkg::KIND_ALLOC:
                            state_next = (used_reg == '0) ? pra_pkg::S_DONE
                                                          : pra_pkg::S_ALLOC_RD;
                        pra_pkg::KIND_TAKE:
                            state_next = (used_reg == '0) ? pra_pkg::S_DONE
                                                          : pra_pkg::S_TAKE_RD;
                        pra_pkg::KIND_FREE:
                            state_next = pra_pkg::S_INS_START;
                        default:
                            state_next = pra_pkg::S_DONE;
                    endcase
                end
            end
            pra_pkg::S_ALLOC_RD:  state_next = pra_pkg::S_ALLOC_CHK;
            pra_pkg::S_ALLOC_CHK:
            begin
                if (fit)
                    state_next = (alloc_len == '0) ? pra_pkg::S_DROP_RD : pra_pkg::S_DONE;
                else
                    state_next = last ? pra_pkg::S_DONE : pra_pkg::S_ALLOC_RD;
            end
            pra_pkg::S_TAKE_RD:   state_next = pra_pkg::S_TAKE_CHK;
            pra_pkg::S_TAKE_CHK:
            begin
                if (hit)
                    state_next = (tk_keep == '0) ? pra_pkg::S_DROP_RD
                                                 : pra_pkg::S_INS_START;
                else
                    state_next = last ? pra_pkg::S_DONE : pra_pkg::S_TAKE_RD;
            end
            pra_pkg::S_INS_START:
                state_next = (len_reg == '0) ? pra_pkg::S_DONE : pra_pkg::S_POS_RD;
            pra_pkg::S_POS_RD:
                state_next = has_cur ? pra_pkg::S_POS_CHK : pra_pkg::S_INS_DEC;
            pra_pkg::S_POS_CHK:
                state_next = pos_less ? pra_pkg::S_POS_RD : pra_pkg::S_INS_DEC;
            pra_pkg::S_INS_DEC:
            begin
                if (mprev)
                    state_next = mnext ? pra_pkg::S_DROP_RD : pra_pkg::S_DONE;
                else if (mnext)
                    state_next = pra_pkg::S_DONE;
                else if (full)
                    state_next = pra_pkg::S_MIN_RD;
                else
                    state_next = pra_pkg::S_UP_START;
            end
            pra_pkg::S_MIN_RD:    state_next = pra_pkg::S_MIN_CHK;
            pra_pkg::S_MIN_CHK:
                state_next = last ? pra_pkg::S_MIN_END : pra_pkg::S_MIN_RD;
            pra_pkg::S_MIN_END:
                state_next = (min_l_reg >= len_reg) ? pra_pkg::S_DONE : pra_pkg::S_DROP_RD;
            pra_pkg::S_DROP_RD:
                state_next = drop_more ? pra_pkg::S_DROP_WR : ret_reg;
            pra_pkg::S_DROP_WR:   state_next = pra_pkg::S_DROP_RD;
            pra_pkg::S_UP_START:  state_next = pra_pkg::S_UP_RD;
            pra_pkg::S_UP_RD:
                state_next = (idx_reg > pos_reg) ? pra_pkg::S_UP_WR : pra_pkg::S_DONE;
            pra_pkg::S_UP_WR:     state_next = pra_pkg::S_UP_RD;
            pra_pkg::S_DONE:
                state_next = load_ok ? pra_pkg::S_IDLE : pra_pkg::S_DONE;
            default:              state_next = pra_pkg::S_IDLE;
        endcase
    end

    // datapath and RAM controls
    always_comb
    begin
        ret_next    = ret_reg;
        idx_next    = idx_reg;
        used_next   = used_reg;
        pos_next    = pos_reg;
        small_next  = small_reg;
        total_next  = total_reg;
        kind_next   = kind_reg;
        first_next  = first_reg;
        len_next    = len_reg;
        cnt_next    = cnt_reg;
        prev_s_next = prev_s_reg;
        prev_l_next = prev_l_reg;
        cur_s_next  = cur_s_reg;
        cur_l_next  = cur_l_reg;
        min_l_next  = min_l_reg;
        result_next = result_reg;
        lost_next   = lost_reg;
        ok_next     = ok_reg;
        rd_en       = 1'b0;
        rd_addr     = idx_reg[AW-1:0];
        wr_en       = 1'b0;
        wr_addr     = idx_reg[AW-1:0];
        wr_data     = rd_data;
        done        = 1'b0;
        unique case (state_reg)
            pra_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    kind_next   = req.kind;
                    first_next  = page_in;
                    cnt_next    = DW'(req.page_count);
                    len_next    = clip_len;
                    idx_next    = '0;
                    result_next = '0;
                    lost_next   = '0;
                    ok_next     = 1'b0;
                end
            end
            pra_pkg::S_ALLOC_RD, pra_pkg::S_TAKE_RD, pra_pkg::S_MIN_RD:
                rd_en = 1'b1;
            pra_pkg::S_ALLOC_CHK:
            begin
                if (fit)
                begin
                    result_next = e_s;
                    ok_next     = 1'b1;
                    total_next  = total_reg - TB'(cnt_reg);
                    ret_next    = pra_pkg::S_DONE;
                    if (alloc_len != '0)
                    begin
                        wr_en   = 1'b1;
                        wr_data = {e_s + W'(cnt_reg), alloc_len};
                    end
                end
                else
                    idx_next = idx_inc;
            end
            pra_pkg::S_TAKE_CHK:
            begin
                if (hit)
                begin
                    ok_next    = 1'b1;
                    total_next = total_reg - TB'(tk_after) - TB'(1);
                    first_next = first_reg + W'(1);
                    len_next   = tk_after;
                    ret_next   = pra_pkg::S_INS_START;
                    if (tk_keep != '0)
                    begin
                        wr_en   = 1'b1;
                        wr_data = {e_s, tk_keep};
                    end
                end
                else
                    idx_next = idx_inc;
            end
            pra_pkg::S_INS_START:
                idx_next = '0;
            pra_pkg::S_POS_RD:
                rd_en = has_cur;
            pra_pkg::S_POS_CHK:
            begin
                if (pos_less)
                begin
                    prev_s_next = e_s;
                    prev_l_next = e_l;
                    idx_next    = idx_inc;
                end
                else
                begin
                    cur_s_next = e_s;
                    cur_l_next = e_l;
                end
            end
            pra_pkg::S_INS_DEC:
            begin
                pos_next = idx_reg;
                if (mprev)
                begin
                    total_next = total_reg + TB'(len_reg);
                    wr_en      = 1'b1;
                    wr_addr    = idx_dec[AW-1:0];
                    ret_next   = pra_pkg::S_DONE;
                    if (mnext)
                        wr_data = {prev_s_reg, prev_l_reg + len_reg + cur_l_reg};
                    else
                        wr_data = {prev_s_reg, prev_l_reg + len_reg};
                end
                else if (mnext)
                begin
                    total_next = total_reg + TB'(len_reg);
                    wr_en      = 1'b1;
                    wr_data    = {first_reg, cur_l_reg + len_reg};
                end
                else if (full)
                    idx_next = '0;
            end
            pra_pkg::S_MIN_CHK:
            begin
                if (min_take)
                begin
                    min_l_next = e_l;
                    small_next = idx_reg;
                end
                idx_next = idx_inc;
            end
            pra_pkg::S_MIN_END:
            begin
                if (min_l_reg >= len_reg)
                    lost_next = len_reg;
                else
                begin
                    // evict the first smallest run, then insert
                    lost_next  = min_l_reg;
                    total_next = total_reg - TB'(min_l_reg);
                    idx_next   = small_reg;
                    ret_next   = pra_pkg::S_UP_START;
                    if (small_reg < pos_reg)
                        pos_next = pos_reg - UW'(1);
                end
            end
            pra_pkg::S_DROP_RD:
            begin
                if (drop_more)
                begin
                    rd_en   = 1'b1;
                    rd_addr = idx_inc[AW-1:0];
                end
                else
                    used_next = used_reg - UW'(1);
            end
            pra_pkg::S_DROP_WR:
            begin
                wr_en    = 1'b1;
                idx_next = idx_inc;
            end
            pra_pkg::S_UP_START:
                idx_next = used_reg;
            pra_pkg::S_UP_RD:
            begin
                if (idx_reg > pos_reg)
                begin
                    rd_en   = 1'b1;
                    rd_addr = idx_dec[AW-1:0];
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = pos_reg[AW-1:0];
                    wr_data    = {first_reg, len_reg};
                    used_next  = used_reg + UW'(1);
                    total_next = total_reg + TB'(len_reg);
                end
            end
            pra_pkg::S_UP_WR:
            begin
                wr_en    = 1'b1;
                idx_next = idx_dec;
            end
            pra_pkg::S_DONE:
                done = load_ok;
            default:
            begin
            end
        endcase
    end

    assign result.result_page = pra_pkg::FIELD_BITS'(result_reg);
    assign result.ok          = ok_reg;
    assign result.pages_lost  = pra_pkg::FIELD_BITS'(lost_reg);
    assign result.total_free  = total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pra_pkg::S_IDLE;
            ret_reg   <= pra_pkg::S_DONE;
            used_reg  <= '0;
            total_reg <= '0;
            idx_reg   <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            used_reg  <= used_next;
            total_reg <= total_next;
            idx_reg   <= idx_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        small_reg  <= small_next;
        kind_reg   <= kind_next;
        first_reg  <= first_next;
        len_reg    <= len_next;
        cnt_reg    <= cnt_next;
        prev_s_reg <= prev_s_next;
        prev_l_reg <= prev_l_next;
        cur_s_reg  <= cur_s_next;
        cur_l_reg  <= cur_l_next;
        min_l_reg  <= min_l_next;
        result_reg <= result_next;
        lost_reg   <= lost_next;
        ok_reg     <= ok_next;
    end

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= UW'(RUN_SLOTS))
        else $error("run count above table size");

    a_rw_apart: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("read and write hit the same entry");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (state_reg == pra_pkg::S_IDLE))
        else $error("done without return to idle");

    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pra_pkg::S_UP_START) |-> !full)
        else $error("insert into full table");

    a_alloc_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pra_pkg::S_ALLOC_CHK) |-> (kind_reg == pra_pkg::KIND_ALLOC))
        else $error("allocate scan for other request");

endmodule

FILE: design/page_run_allocator.sv
// ----------------------------------------------------------------------------
// page_run_allocator
// First-fit page run allocator with coalescing, table held in one RAM.
// ----------------------------------------------------------------------------
// Steps: an allocate or take on an empty table, or an unused kind, goes
//   straight to the response; else entries are scanned and moved one at a
//   time, plus insert bookkeeping. The longest request is a take whose tail
//   goes back into a full table (take scan, position scan, smallest scan, two shifts).
// Throughput: one request at a time; a new request is taken while the
//   previous response waits in the output register.
// Reset: run table empty, free total zero; no clearing pass is needed.
module page_run_allocator #(
    parameter int RUN_SLOTS        = 128,
    parameter int PAGE_NUMBER_BITS = 40
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  pra_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output pra_pkg::rsp_t rsp
);

    localparam int AW = $clog2(RUN_SLOTS);
    localparam int EW = 2 * PAGE_NUMBER_BITS;

    logic          rd_en, wr_en, done, load_ok;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [EW-1:0] rd_data, wr_data;
    pra_pkg::rsp_t result;
    logic          rsp_valid_reg, rsp_valid_next;
    pra_pkg::rsp_t rsp_reg;

    pra_ram #(
        .WIDTH (EW),
        .DEPTH (RUN_SLOTS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pra_engine #(
        .RUN_SLOTS        (RUN_SLOTS),
        .PAGE_NUMBER_BITS (PAGE_NUMBER_BITS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .load_ok   (load_ok),
        .done      (done),
        .result    (result),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    assign load_ok        = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid_next = done || (rsp_valid_reg && rsp_stall);
    assign rsp_valid      = rsp_valid_reg;
    assign rsp            = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else
            rsp_valid_reg <= rsp_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (done)
            rsp_reg <= result;
    end

endmodule

FILE: tb/page_run_allocator_tb.sv
// ----------------------------------------------------------------------------
// page_run_allocator_tb
// Self-checking bench: each accepted request runs through a behavioral copy
// of the run table, and every response is compared with the oldest predicted
// one. Both handshakes see random gaps and stalls, plus one long output hold.
// ----------------------------------------------------------------------------
module page_run_allocator_tb;

    localparam int SLOTS = 128;
    localparam longint unsigned TOP_PAGE = (64'd1 << 40) - 1;
    localparam longint unsigned MASK40 = (64'd1 << 40) - 1;
    localparam longint unsigned MASK41 = (64'd1 << 41) - 1;
    localparam pra_pkg::kind_t KIND_NONE = 2'd3;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           req_valid = 1'b0;
    logic           req_stall;
    pra_pkg::req_t  req = '0;
    logic           rsp_valid;
    logic           rsp_stall = 1'b0;
    pra_pkg::rsp_t  rsp;

    // predicted run table
    longint unsigned run_base[SLOTS];
    longint unsigned run_len[SLOTS];
    int              runs_held = 0;
    longint unsigned pages_free = 0;

    pra_pkg::rsp_t pending_rsp[$];
    int   fail_count = 0;
    int   hold_cycles = 0;
    bit   quiet_out = 1'b0;

    page_run_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    initial
    begin
        #200000000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic void remove_run(int at);
        for (int j = at; j + 1 < runs_held; j++)
        begin
            run_base[j] = run_base[j+1];
            run_len[j]  = run_len[j+1];
        end
        runs_held--;
    endfunction

    // insert with coalescing; returns pages dropped by a full table
    function automatic longint unsigned add_run(longint unsigned first,
                                                longint unsigned len);
        int pos = 0;
        int smallest = 0;
        longint unsigned lost = 0;
        if (len == 0)
            return 0;
        while (pos < runs_held && run_base[pos] < first)
            pos++;
        if (pos > 0 && run_base[pos-1] + run_len[pos-1] == first)
        begin
            run_len[pos-1] += len;
            pages_free += len;
            if (pos < runs_held && first + len == run_base[pos])
            begin
                run_len[pos-1] += run_len[pos];
                remove_run(pos);
            end
            return 0;
        end
        if (pos < runs_held && first + len == run_base[pos])
        begin
            run_base[pos] = first;
            run_len[pos] += len;
            pages_free += len;
            return 0;
        end
        if (runs_held >= SLOTS)
        begin
            for (int j = 1; j < runs_held; j++)
                if (run_len[j] < run_len[smallest])
                    smallest = j;
            if (run_len[smallest] >= len)
                return len;
            lost = run_len[smallest];
            pages_free -= lost;
            remove_run(smallest);
            if (smallest < pos)
                pos--;
        end
        for (int j = runs_held; j > pos; j--)
        begin
            run_base[j] = run_base[j-1];
            run_len[j]  = run_len[j-1];
        end
        run_base[pos] = first;
        run_len[pos]  = len;
        runs_held++;
        pages_free += len;
        return lost;
    endfunction

    function automatic pra_pkg::rsp_t predict_response(pra_pkg::req_t r);
        pra_pkg::rsp_t   e = '0;
        longint unsigned page = r.page_number;
        longint unsigned count = r.page_count;
        longint unsigned tail;
        longint unsigned lost = 0;
        if (r.kind == pra_pkg::KIND_ALLOC)
        begin
            for (int j = 0; j < runs_held; j++)
                if (run_len[j] >= count)
                begin
                    e.result_page = 40'(run_base[j]);
                    run_base[j] += count;
                    run_len[j]  -= count;
                    pages_free  -= count;
                    if (run_len[j] == 0)
                        remove_run(j);
                    e.ok = 1'b1;
                    break;
                end
        end
        else if (r.kind == pra_pkg::KIND_FREE)
        begin
            if (page >= TOP_PAGE)
                count = 0;
            else if (count > TOP_PAGE - page)
                count = TOP_PAGE - page;
            lost = add_run(page, count);
        end
        else if (r.kind == pra_pkg::KIND_TAKE)
        begin
            for (int j = 0; j < runs_held; j++)
                if (page >= run_base[j] && page - run_base[j] < run_len[j])
                begin
                    tail = run_base[j] + run_len[j] - page - 1;
                    run_len[j] = page - run_base[j];
                    pages_free -= tail + 1;
                    if (run_len[j] == 0)
                        remove_run(j);
                    lost = add_run(page + 1, tail);
                    e.ok = 1'b1;
                    break;
                end
        end
        e.pages_lost = 40'(lost & MASK40);
        e.total_free = 41'(pages_free & MASK41);
        return e;
    endfunction

    function automatic int pick_gap();
        int r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // called just after a rising edge; returns just after the accepting edge
    task automatic send_request(pra_pkg::kind_t k, longint unsigned page,
                                longint unsigned count, bit no_gap = 1'b0);
        pra_pkg::req_t r;
        bit   st;
        int   gap;
        r.kind = k;
        r.page_number = page[39:0];
        r.page_count = count[39:0];
        req <= r;
        req_valid <= 1'b1;
        do
        begin
            @(negedge clk);
            st = req_stall;
            @(posedge clk);
        end
        while (st);
        pending_rsp.push_back(predict_response(r));
        gap = no_gap ? 0 : pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // output stall: random, with rare long bursts and an external hold
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                rsp_stall <= 1'b1;
                hold_cycles--;
            end
            else if (quiet_out)
                rsp_stall <= 1'b0;
            else if ($urandom_range(0, 299) == 0)
            begin
                rsp_stall <= 1'b1;
                hold_cycles = $urandom_range(20, 60);
            end
            else
                rsp_stall <= ($urandom_range(0, 3) == 0);
        end
    end

    initial
    begin
        pra_pkg::rsp_t got;
        pra_pkg::rsp_t want;
        bit   v;
        bit   s;
        forever
        begin
            @(negedge clk);
            v = rsp_valid;
            s = rsp_stall;
            got = rsp;
            if (rst_n && v && !s)
            begin
                if (pending_rsp.size() == 0)
                begin
                    $error("response with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    want = pending_rsp.pop_front();
                    if (got.result_page !== want.result_page)
                    begin
                        $error("result_page exp %h got %h", want.result_page, got.result_page);
                        fail_count++;
                    end
                    if (got.ok !== want.ok)
                    begin
                        $error("ok exp %b got %b", want.ok, got.ok);
                        fail_count++;
                    end
                    if (got.pages_lost !== want.pages_lost)
                    begin
                        $error("pages_lost exp %h got %h", want.pages_lost, got.pages_lost);
                        fail_count++;
                    end
                    if (got.total_free !== want.total_free)
                    begin
                        $error("total_free exp %h got %h", want.total_free, got.total_free);
                        fail_count++;
                    end
                end
            end
        end
    end

    task automatic test_corner_cases();
        send_request(pra_pkg::KIND_ALLOC, 0, 0);
        send_request(pra_pkg::KIND_ALLOC, 0, 5);
        send_request(KIND_NONE, MASK40, MASK40);
        send_request(pra_pkg::KIND_TAKE, 7, 0);
        send_request(pra_pkg::KIND_FREE, 100, 0);
        send_request(pra_pkg::KIND_FREE, TOP_PAGE, 50);
        send_request(pra_pkg::KIND_FREE, TOP_PAGE - 10, 100);
        send_request(pra_pkg::KIND_ALLOC, 0, 0);
        send_request(pra_pkg::KIND_TAKE, TOP_PAGE - 2, 0);
        send_request(pra_pkg::KIND_TAKE, TOP_PAGE - 6, MASK40);
        send_request(pra_pkg::KIND_ALLOC, 0, 50);
        // three overlapping full-range frees wrap the total
        repeat (3) send_request(pra_pkg::KIND_FREE, 0, MASK40);
        send_request(pra_pkg::KIND_ALLOC, 0, MASK40);
        repeat (3) send_request(pra_pkg::KIND_ALLOC, 0, TOP_PAGE);
        send_request(pra_pkg::KIND_FREE, 200, 10);
        send_request(pra_pkg::KIND_FREE, 220, 10);
        send_request(pra_pkg::KIND_FREE, 210, 10);
        send_request(pra_pkg::KIND_FREE, 190, 10);
        send_request(pra_pkg::KIND_FREE, 230, 5);
        send_request(pra_pkg::KIND_TAKE, 200, 0);
        send_request(pra_pkg::KIND_TAKE, 190, 0);
        send_request(pra_pkg::KIND_ALLOC, 0, 30);
    endtask

    task automatic test_full_table();
        longint unsigned base = 20000;
        for (int i = 0; i < 150; i++)
            send_request(pra_pkg::KIND_FREE, base + i * 16, $urandom_range(1, 8));
        send_request(pra_pkg::KIND_FREE, base + 4000, 1);
        send_request(pra_pkg::KIND_FREE, base + 4100, 12);
        for (int i = 0; i < 15; i++)
            send_request(pra_pkg::KIND_TAKE, base + $urandom_range(0, 150 * 16), 0);
    endtask

    task automatic test_output_hold();
        fork
            hold_cycles = 3000;
            for (int i = 0; i < 20; i++)
                send_request(pra_pkg::KIND_FREE, 60000 + i * 4, 2, 1'b1);
        join
    endtask

    task automatic test_random_mix(int n);
        pra_pkg::kind_t  k;
        longint unsigned page;
        longint unsigned count;
        for (int i = 0; i < n; i++)
        begin
            if (i == n / 2)
                quiet_out = 1'b1;
            if (i == n / 2 + 100)
                quiet_out = 1'b0;
            case ($urandom_range(0, 99)) inside
                [0:39]:  k = pra_pkg::KIND_ALLOC;
                [40:79]: k = pra_pkg::KIND_FREE;
                [80:97]: k = pra_pkg::KIND_TAKE;
                default: k = KIND_NONE;
            endcase
            if ($urandom_range(0, 19) == 0)
            begin
                page  = {$urandom(), $urandom()} & MASK40;
                count = {$urandom(), $urandom()} & MASK40;
                if (k == pra_pkg::KIND_ALLOC && $urandom_range(0, 1))
                    count = $urandom_range(0, 1000000);
            end
            else
            begin
                page  = $urandom_range(0, 4095);
                count = $urandom_range(0, 24);
            end
            send_request(k, page, count);
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_corner_cases();
        test_full_table();
        test_output_hold();
        test_random_mix(1240);
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (1000) @(posedge clk);
        if (fail_count == 0 && pending_rsp.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: sim.f
design/pra_pkg.sv
design/pra_ram.sv
design/pra_engine.sv
design/page_run_allocator.sv
tb/page_run_allocator_tb.sv
